// File: hw/rtl/npr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// npr_pkg
// Shared types, constants and helpers for the nearest point on rectangle set
// block.
// ----------------------------------------------------------------------------
package npr_pkg;

  // table geometry
  localparam int MAX_RECTS = 16;
  localparam int IDX_W     = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam int CNT_W     = $clog2(MAX_RECTS + 1);

  // field and datapath widths
  localparam int COORD_W = 16;           // signed Q12.4 coordinate
  localparam int SIZE_W  = 15;           // unsigned Q11.4 width or height
  localparam int EDGE_W  = COORD_W + 1;  // right and bottom edges
  localparam int DIFF_W  = EDGE_W + 1;   // candidate minus query point
  localparam int SQ_W    = 2 * DIFF_W - 2;
  localparam int DIST_W  = SQ_W + 1;

  localparam int COORD_MAX = 2 ** (COORD_W - 1) - 1;
  localparam int COORD_MIN = -(2 ** (COORD_W - 1));

  // command codes
  typedef enum logic [1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_ERASE = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_QUERY = 2'd3
  } npr_func_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_INDEX = 2'd2
  } npr_status_t;

  // one stored rectangle
  typedef struct packed {
    logic signed [COORD_W-1:0] left;
    logic signed [COORD_W-1:0] top;
    logic        [SIZE_W-1:0]  wid;
    logic        [SIZE_W-1:0]  hgt;
  } npr_rect_t;

  // control from the sequencer to the evaluator
  typedef struct packed {
    logic start;   // clear running best at query start
    logic valid;   // read data holds a rectangle of the query sweep
  } npr_eval_ctl_t;

  // status from the evaluator back to the sequencer
  typedef struct packed {
    logic                     busy;
    logic                     have;
    logic                     hit;
    logic signed [EDGE_W-1:0] best_x;
    logic signed [EDGE_W-1:0] best_y;
  } npr_eval_res_t;

  // clamp an edge-width value into the coordinate range
  function automatic logic signed [COORD_W-1:0] sat_coord(
    input logic signed [EDGE_W-1:0] v
  );
    logic signed [EDGE_W-1:0] hi_lim;
    logic signed [EDGE_W-1:0] lo_lim;
    hi_lim = EDGE_W'(COORD_MAX);
    lo_lim = EDGE_W'(COORD_MIN);
    if (v > hi_lim) begin
      return COORD_W'(hi_lim);
    end else if (v < lo_lim) begin
      return COORD_W'(lo_lim);
    end else begin
      return COORD_W'(v);
    end
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/npr_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// npr_in_if / npr_out_if
// Valid/ready channels for commands into and results out of the block.
// ----------------------------------------------------------------------------
interface npr_in_if;
  import npr_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [1:0]                func;
  logic signed [COORD_W-1:0] coord_x;
  logic signed [COORD_W-1:0] coord_y;
  logic [SIZE_W-1:0]         rect_width;
  logic [SIZE_W-1:0]         rect_height;
  logic [3:0]                entry_index;

  modport source (
    output valid, func, coord_x, coord_y, rect_width, rect_height, entry_index,
    input  ready
  );
  modport sink (
    input  valid, func, coord_x, coord_y, rect_width, rect_height, entry_index,
    output ready
  );
endinterface

interface npr_out_if;
  import npr_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] near_x;
  logic signed [COORD_W-1:0] near_y;
  logic                      contained;
  logic [1:0]                status;
  logic [4:0]                entry_count;

  modport source (
    output valid, near_x, near_y, contained, status, entry_count,
    input  ready
  );
  modport sink (
    input  valid, near_x, near_y, contained, status, entry_count,
    output ready
  );
endinterface
`default_nettype wire

// File: hw/rtl/npr_table_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// npr_table_mem
// Rectangle table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module npr_table_mem
  import npr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [IDX_W-1:0] waddr,
  input  wire npr_rect_t        wdata,
  input  wire logic             re,
  input  wire logic [IDX_W-1:0] raddr,
  output npr_rect_t             rdata
);

  npr_rect_t mem [MAX_RECTS];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/npr_eval.sv
`default_nettype none
// ----------------------------------------------------------------------------
// npr_eval
// Per-rectangle candidate pipeline: edges, clamp or edge snap, squared
// distance, then running minimum and containment.
// ----------------------------------------------------------------------------
module npr_eval
  import npr_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire npr_eval_ctl_t             ctl,
  input  wire npr_rect_t                 rect,
  input  wire logic signed [COORD_W-1:0] px,
  input  wire logic signed [COORD_W-1:0] py,
  output npr_eval_res_t                  res
);

  // stage 1 registers
  logic                     v1;
  logic signed [EDGE_W-1:0] s1_left, s1_top, s1_right, s1_bottom;

  // stage 2 registers
  logic                     v2;
  logic                     s2_inside;
  logic signed [EDGE_W-1:0] s2_cx, s2_cy;

  // stage 3 registers
  logic                     v3;
  logic                     s3_inside;
  logic signed [EDGE_W-1:0] s3_cx, s3_cy;
  logic [SQ_W-1:0]          s3_sqx, s3_sqy;

  // running result
  logic                     have;
  logic                     inside_acc;
  logic [DIST_W-1:0]        best;
  logic signed [EDGE_W-1:0] best_x, best_y;

  // stage 1 comb
  logic signed [EDGE_W-1:0] right_c, bottom_c;

  // stage 2 comb
  logic signed [EDGE_W-1:0] px_e, py_e;
  logic signed [EDGE_W-1:0] dpx, dnx, dpy, dny;
  logic                     in_x, in_y, cont_c;
  logic signed [EDGE_W-1:0] cx_c, cy_c;
  logic signed [EDGE_W-1:0] clx_lo, cly_lo;

  // stage 3 comb
  logic signed [DIFF_W-1:0]   dx, dy;
  logic signed [2*DIFF_W-1:0] sqx_full, sqy_full;

  // stage 4 comb
  logic [DIST_W-1:0] sum_sq;

  // right and bottom edges
  always_comb begin
    right_c  = EDGE_W'(rect.left) + $signed({2'b00, rect.wid});
    bottom_c = EDGE_W'(rect.top)  + $signed({2'b00, rect.hgt});
  end

  always_ff @(posedge clk) begin
    s1_left   <= EDGE_W'(rect.left);
    s1_top    <= EDGE_W'(rect.top);
    s1_right  <= right_c;
    s1_bottom <= bottom_c;
  end

  // containment and candidate point
  always_comb begin
    px_e   = EDGE_W'(px);
    py_e   = EDGE_W'(py);
    cont_c = (s1_left <= px_e) && (px_e < s1_right) &&
             (s1_top <= py_e) && (py_e < s1_bottom);
    in_x   = (s1_left < px_e) && (px_e < s1_right);
    in_y   = (s1_top < py_e) && (py_e < s1_bottom);
    dpx    = s1_right - px_e;
    dnx    = px_e - s1_left;
    dpy    = s1_bottom - py_e;
    dny    = py_e - s1_top;
    clx_lo = (px_e < s1_right) ? px_e : s1_right;
    cly_lo = (py_e < s1_bottom) ? py_e : s1_bottom;
    if (!(in_x && in_y)) begin
      // outside or on the border: clamp into the box
      cx_c = (s1_left > clx_lo) ? s1_left : clx_lo;
      cy_c = (s1_top > cly_lo) ? s1_top : cly_lo;
    end else if (dpx <= dnx && dpx <= dpy && dpx <= dny) begin
      cx_c = s1_right;
      cy_c = py_e;
    end else if (dnx <= dpy && dnx <= dny) begin
      cx_c = s1_left;
      cy_c = py_e;
    end else if (dpy <= dny) begin
      cx_c = px_e;
      cy_c = s1_bottom;
    end else begin
      cx_c = px_e;
      cy_c = s1_top;
    end
  end

  always_ff @(posedge clk) begin
    s2_inside <= cont_c;
    s2_cx     <= cx_c;
    s2_cy     <= cy_c;
  end

  // squared offsets
  always_comb begin
    dx       = DIFF_W'(s2_cx) - DIFF_W'(px);
    dy       = DIFF_W'(s2_cy) - DIFF_W'(py);
    sqx_full = dx * dx;
    sqy_full = dy * dy;
  end

  always_ff @(posedge clk) begin
    s3_inside <= s2_inside;
    s3_cx     <= s2_cx;
    s3_cy     <= s2_cy;
    s3_sqx    <= sqx_full[SQ_W-1:0];
    s3_sqy    <= sqy_full[SQ_W-1:0];
  end

  // distance sum
  assign sum_sq = DIST_W'(s3_sqx) + DIST_W'(s3_sqy);

  // running minimum, first one wins a tie
  always_ff @(posedge clk) begin
    if (v3 && (!have || sum_sq < best)) begin
      best   <= sum_sq;
      best_x <= s3_cx;
      best_y <= s3_cy;
    end
  end

  // valid pipe and accumulator flags
  always_ff @(posedge clk) begin
    if (rst) begin
      v1         <= 1'b0;
      v2         <= 1'b0;
      v3         <= 1'b0;
      have       <= 1'b0;
      inside_acc <= 1'b0;
    end else begin
      v1 <= ctl.valid;
      v2 <= v1;
      v3 <= v2;
      if (ctl.start) begin
        have       <= 1'b0;
        inside_acc <= 1'b0;
      end else if (v3) begin
        have       <= 1'b1;
        inside_acc <= inside_acc | s3_inside;
      end
    end
  end

  always_comb begin
    res.busy   = v1 | v2 | v3;
    res.have   = have;
    res.hit    = inside_acc;
    res.best_x = best_x;
    res.best_y = best_y;
  end

endmodule
`default_nettype wire

// File: hw/rtl/nearest_point_on_rectangle_set.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_point_on_rectangle_set
// Rectangle table with add, erase and clear commands and a nearest point
// plus containment query over all stored rectangles.
// ----------------------------------------------------------------------------
// Sequence, input transfer to result valid: add, clear and a rejected erase
//   pass S_EXEC and S_DONE; erase alternates S_SHR and S_SHW over the entries
//   above entry_index; query reads each stored rectangle, then drains the eval.
// Throughput: one command at a time; the single table read port paces the
//   query sweep at one rectangle per cycle; erase reads, then writes, each
//   moved entry. A new command is taken while a result waits to transfer.
// Reset: rst clears the count and all control; table contents are not reset.
// ----------------------------------------------------------------------------
module nearest_point_on_rectangle_set
  import npr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  npr_in_if.sink    in_ch,
  npr_out_if.source out_ch
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_EXEC   = 7'b0000010,
    S_SHR    = 7'b0000100,
    S_SHW    = 7'b0001000,
    S_QRD    = 7'b0010000,
    S_QDRAIN = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t state;

  // table count and sweep pointers
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] ptr;
  logic [CNT_W-1:0] qptr;
  logic             qread_q;

  // latched command
  npr_func_t                 cmd_func;
  logic signed [COORD_W-1:0] cmd_x, cmd_y;
  logic [SIZE_W-1:0]         cmd_w, cmd_h;
  logic [3:0]                cmd_idx;

  // pending result
  logic signed [COORD_W-1:0] res_x, res_y;
  logic                      res_in;
  npr_status_t               res_status;

  // output register
  logic                      out_valid;
  logic signed [COORD_W-1:0] out_x, out_y;
  logic                      out_in;
  npr_status_t               out_status;
  logic [4:0]                out_count;

  // memory ports
  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  npr_rect_t        mem_wdata, mem_rdata;

  npr_eval_ctl_t ev_ctl;
  npr_eval_res_t ev_res;

  logic in_xfer;
  logic table_full;
  logic bad_index;
  logic shift_more;
  logic q_more;

  assign in_ch.ready = (state == S_IDLE);
  assign in_xfer     = in_ch.valid & in_ch.ready;
  assign table_full  = (32'(count) >= 32'(MAX_RECTS));
  assign bad_index   = (32'(cmd_idx) >= 32'(count));
  assign shift_more  = (CNT_W'(ptr) + CNT_W'(1)) < count;
  assign q_more      = qptr < count;

  // memory and evaluator control
  always_comb begin
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = ptr;
    mem_raddr    = ptr + IDX_W'(1);
    mem_wdata    = mem_rdata;
    ev_ctl.start = 1'b0;
    ev_ctl.valid = qread_q;
    unique case (state)
      S_EXEC: begin
        if (cmd_func == FUNC_ADD && !table_full) begin
          mem_we         = 1'b1;
          mem_waddr      = count[IDX_W-1:0];
          mem_wdata.left = cmd_x;
          mem_wdata.top  = cmd_y;
          mem_wdata.wid  = cmd_w;
          mem_wdata.hgt  = cmd_h;
        end
        ev_ctl.start = (cmd_func == FUNC_QUERY);
      end
      S_SHR: begin
        mem_re = shift_more;
      end
      S_SHW: begin
        // read of ptr+1 finished last cycle, no overlap with this write
        mem_we = 1'b1;
      end
      S_QRD: begin
        mem_re    = q_more;
        mem_raddr = qptr[IDX_W-1:0];
      end
      S_IDLE, S_QDRAIN, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // command latch
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_func <= npr_func_t'(in_ch.func);
      cmd_x    <= in_ch.coord_x;
      cmd_y    <= in_ch.coord_y;
      cmd_w    <= in_ch.rect_width;
      cmd_h    <= in_ch.rect_height;
      cmd_idx  <= in_ch.entry_index;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      qread_q   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      qread_q <= (state == S_QRD) && q_more;
      // a transfer empties the output register unless a new result moves in
      if (out_ch.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_x      <= '0;
          res_y      <= '0;
          res_in     <= 1'b0;
          case (cmd_func)
            FUNC_ADD: begin
              if (table_full) begin
                res_status <= ST_FULL;
              end else begin
                res_status <= ST_OK;
                count      <= count + CNT_W'(1);
              end
              state <= S_DONE;
            end
            FUNC_ERASE: begin
              if (bad_index) begin
                res_status <= ST_BAD_INDEX;
                state      <= S_DONE;
              end else begin
                res_status <= ST_OK;
                ptr        <= IDX_W'(cmd_idx);
                state      <= S_SHR;
              end
            end
            FUNC_CLEAR: begin
              res_status <= ST_OK;
              count      <= '0;
              state      <= S_DONE;
            end
            default: begin
              res_status <= ST_OK;
              qptr       <= '0;
              state      <= S_QRD;
            end
          endcase
        end
        S_SHR: begin
          if (shift_more) begin
            state <= S_SHW;
          end else begin
            count <= count - CNT_W'(1);
            state <= S_DONE;
          end
        end
        S_SHW: begin
          ptr   <= ptr + IDX_W'(1);
          state <= S_SHR;
        end
        S_QRD: begin
          if (q_more) begin
            qptr <= qptr + CNT_W'(1);
          end else begin
            state <= S_QDRAIN;
          end
        end
        S_QDRAIN: begin
          if (!qread_q && !ev_res.busy) begin
            res_in <= ev_res.hit;
            if (ev_res.have) begin
              res_x <= sat_coord(ev_res.best_x);
              res_y <= sat_coord(ev_res.best_y);
            end else begin
              res_x <= cmd_x;
              res_y <= cmd_y;
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ch.ready) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || out_ch.ready)) begin
      out_x      <= res_x;
      out_y      <= res_y;
      out_in     <= res_in;
      out_status <= res_status;
      out_count  <= 5'(count);
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.near_x      = out_x;
  assign out_ch.near_y      = out_y;
  assign out_ch.contained   = out_in;
  assign out_ch.status      = out_status;
  assign out_ch.entry_count = out_count;

  npr_table_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  npr_eval u_eval (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ev_ctl),
    .rect (mem_rdata),
    .px   (cmd_x),
    .py   (cmd_y),
    .res  (ev_res)
  );

  // table never holds more than its capacity
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= 32'(MAX_RECTS))
    else $error("rectangle count above capacity");

  // evaluator pipeline is empty whenever a new command can be taken
  a_eval_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (!ev_res.busy && !qread_q))
    else $error("evaluator busy while idle");

  // no table write while a query sweeps the table
  a_no_write_query: assert property (@(posedge clk) disable iff (rst)
    (state == S_QRD || state == S_QDRAIN) |-> !mem_we)
    else $error("table write during query");

endmodule
`default_nettype wire

// File: test/nearest_point_on_rectangle_set_checker.sv
// ----------------------------------------------------------------------------
// npr_result_checker
// Watches the command and result channels of the rectangle set block, keeps
// its own copy of the rectangle table, works out the answer to each command
// and compares every result transfer against the oldest answer still owed.
// ----------------------------------------------------------------------------
module npr_result_checker
  import npr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  npr_in_if    cmd,
  npr_out_if   res,
  output int   mismatches,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SHOWN_MAX = 10;

  // one answer as it appears on the result channel
  typedef struct packed {
    logic signed [COORD_W-1:0] near_x;
    logic signed [COORD_W-1:0] near_y;
    logic                      contained;
    logic [1:0]                status;
    logic [4:0]                entry_count;
  } npr_result_t;

  npr_rect_t   boxes [MAX_RECTS];
  int          box_count;
  npr_result_t expected_results [$];

  function automatic longint limit(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  // apply one command to the table copy and return the answer it gives
  function automatic npr_result_t apply_command(
    input npr_func_t                 f,
    input logic signed [COORD_W-1:0] x,
    input logic signed [COORD_W-1:0] y,
    input logic [SIZE_W-1:0]         w,
    input logic [SIZE_W-1:0]         h,
    input logic [3:0]                idx
  );
    npr_result_t  r;
    longint       px, py, lft, tp, rgt, btm, cx, cy, bx, by;
    longint       dpx, dnx, dpy, dny, m;
    longint unsigned d, best;
    r = '0;
    case (f)
      FUNC_ADD: begin
        if (box_count >= MAX_RECTS) begin
          r.status = ST_FULL;
        end else begin
          boxes[box_count] = '{left: x, top: y, wid: w, hgt: h};
          box_count++;
        end
      end
      FUNC_ERASE: begin
        if (int'(idx) >= box_count) begin
          r.status = ST_BAD_INDEX;
        end else begin
          for (int i = int'(idx); i + 1 < box_count; i++) boxes[i] = boxes[i + 1];
          box_count--;
        end
      end
      FUNC_CLEAR: begin
        box_count = 0;
      end
      default: begin
        // query: empty table answers with the point itself
        px = x;
        py = y;
        bx = px;
        by = py;
        best = 0;
        for (int i = 0; i < box_count; i++) begin
          lft = boxes[i].left;
          tp  = boxes[i].top;
          rgt = boxes[i].wid;
          rgt += lft;
          btm = boxes[i].hgt;
          btm += tp;
          // left and top edges inclusive, right and bottom exclusive
          if (lft <= px && px < rgt && tp <= py && py < btm) r.contained = 1'b1;
          if (lft < px && px < rgt && tp < py && py < btm) begin
            // strictly inside: move to the nearest edge, +x -x +y -y on ties
            dpx = rgt - px;
            dnx = px - lft;
            dpy = btm - py;
            dny = py - tp;
            m = dpx;
            if (dnx < m) m = dnx;
            if (dpy < m) m = dpy;
            if (dny < m) m = dny;
            if (m == dpx) begin
              cx = rgt;
              cy = py;
            end else if (m == dnx) begin
              cx = lft;
              cy = py;
            end else if (m == dpy) begin
              cx = px;
              cy = btm;
            end else begin
              cx = px;
              cy = tp;
            end
          end else begin
            cx = limit(px, lft, rgt);
            cy = limit(py, tp, btm);
          end
          d = (cx - px) * (cx - px) + (cy - py) * (cy - py);
          // first minimum wins
          if (i == 0 || d < best) begin
            best = d;
            bx = cx;
            by = cy;
          end
        end
        r.near_x = COORD_W'(limit(bx, COORD_MIN, COORD_MAX));
        r.near_y = COORD_W'(limit(by, COORD_MIN, COORD_MAX));
      end
    endcase
    r.entry_count = 5'(box_count);
    return r;
  endfunction

  function automatic string show(input npr_result_t r);
    return $sformatf("x=%0d y=%0d contained=%0b status=%0d count=%0d",
                     r.near_x, r.near_y, r.contained, r.status, r.entry_count);
  endfunction

  task automatic note_failure(input string msg);
    mismatches++;
    if (mismatches <= SHOWN_MAX) $display("[%0t] %s", $realtime, msg);
  endtask

  // result transfers first, then command transfers of the same edge
  always @(posedge clk) begin : watch
    npr_result_t want;
    npr_result_t got;
    if (rst) begin
      box_count = 0;
      mismatches = 0;
      expected_results.delete();
    end else begin
      if (res.valid && res.ready) begin
        got = '{near_x: res.near_x, near_y: res.near_y, contained: res.contained,
                status: res.status, entry_count: res.entry_count};
        if (expected_results.size() == 0) begin
          note_failure({"result with nothing owed: ", show(got)});
        end else begin
          want = expected_results.pop_front();
          if (got.near_x !== want.near_x || got.near_y !== want.near_y ||
              got.contained !== want.contained || got.status !== want.status ||
              got.entry_count !== want.entry_count) begin
            note_failure({"mismatch: expected ", show(want), " got ", show(got)});
          end
        end
      end
      if (cmd.valid && cmd.ready) begin
        want = apply_command(npr_func_t'(cmd.func), cmd.coord_x, cmd.coord_y,
                             cmd.rect_width, cmd.rect_height, cmd.entry_index);
        expected_results = {expected_results, want};
      end
    end
    outstanding = expected_results.size();
  end

endmodule

// File: test/nearest_point_on_rectangle_set_test.sv
// ----------------------------------------------------------------------------
// nearest_point_on_rectangle_set_test
// Drives commands into the rectangle set block: a directed pass over edges,
// ties, zero-size and out-of-range rectangles, then random table building
// and queries under three idling mixes, with a long result hold-off and a
// full drain. The checker beside the block scores every result.
// ----------------------------------------------------------------------------
module nearest_point_on_rectangle_set_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF      = 10;
  localparam int RESET_CYCLES  = 9;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_ITEMS   = 166;
  localparam int DRAIN_CYCLES  = 64;
  localparam int TABLE_SLOTS   = npr_pkg::MAX_RECTS;

  logic clk = 1'b0;
  logic rst;
  int   tx_idle_pct;
  int   rx_idle_pct;
  int   hold_requests;
  int   mismatches;
  int   outstanding;
  int   cycle_count = 0;

  // rough view of the table, only used to aim the stimulus
  int                 table_fill;
  npr_pkg::npr_rect_t recent [TABLE_SLOTS];
  int                 recent_n;

  npr_in_if  cmd_ch ();
  npr_out_if res_ch ();

  nearest_point_on_rectangle_set DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (cmd_ch),
    .out_ch (res_ch)
  );

  npr_result_checker result_check (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd_ch),
    .res         (res_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // clock
  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side: random stalls plus a long hold-off on request
  initial begin : result_sink
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // offer one command and wait for its transfer
  task automatic issue(input npr_pkg::npr_func_t f, input int x, input int y,
                       input int w, input int h, input int idx);
    logic took;
    while ($urandom_range(99) < tx_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid       <= 1'b1;
    cmd_ch.func        <= f;
    cmd_ch.coord_x     <= 16'(x);
    cmd_ch.coord_y     <= 16'(y);
    cmd_ch.rect_width  <= 15'(w);
    cmd_ch.rect_height <= 15'(h);
    cmd_ch.entry_index <= 4'(idx);
    // ready is stable mid-cycle, the transfer happens at the next edge
    do begin
      @(negedge clk);
      took = cmd_ch.ready;
      @(posedge clk);
    end while (!took);
    case (f)
      npr_pkg::FUNC_ADD: begin
        if (table_fill < TABLE_SLOTS) begin
          table_fill++;
          recent[recent_n % TABLE_SLOTS] = '{left: 16'(x), top: 16'(y),
                                             wid: 15'(w), hgt: 15'(h)};
          recent_n++;
        end
      end
      npr_pkg::FUNC_ERASE: if ((idx & 15) < table_fill) table_fill--;
      npr_pkg::FUNC_CLEAR: table_fill = 0;
      default: ;
    endcase
  endtask

  // hold the sender until every result owed has transferred
  task automatic wait_drained();
    cmd_ch.valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  function automatic int rand_coord();
    if ($urandom_range(6) == 0) return $urandom;
    return int'($urandom_range(4000)) - 2000;
  endfunction

  function automatic int rand_size();
    case ($urandom_range(9))
      0:       return 0;
      1:       return $urandom;
      default: return $urandom_range(800);
    endcase
  endfunction

  // mostly table building and aimed queries, some raw noise
  task automatic random_command();
    int pick, x, y, w, h, idx, l, t, rw, rh;
    npr_pkg::npr_rect_t r;
    pick = $urandom_range(99);
    x = rand_coord();
    y = rand_coord();
    w = rand_size();
    h = rand_size();
    idx = $urandom_range(15);
    if (pick < 8) begin
      issue(npr_pkg::npr_func_t'($urandom_range(3)), $urandom, $urandom, $urandom,
            $urandom, $urandom);
    end else if (pick < 45) begin
      issue(npr_pkg::FUNC_ADD, x, y, w, h, idx);
    end else if (pick < 58) begin
      if (table_fill > 0 && $urandom_range(4) != 0) idx = $urandom_range(table_fill - 1);
      issue(npr_pkg::FUNC_ERASE, x, y, w, h, idx);
    end else if (pick < 61) begin
      issue(npr_pkg::FUNC_CLEAR, x, y, w, h, idx);
    end else begin
      if (recent_n > 0 && $urandom_range(7) != 0) begin
        r = recent[$urandom_range(((recent_n < TABLE_SLOTS) ? recent_n : TABLE_SLOTS) - 1)];
        l = r.left;
        t = r.top;
        rw = r.wid;
        rh = r.hgt;
        case ($urandom_range(4))
          0: begin
            x = l + $urandom_range(rw);
            y = t + $urandom_range(rh);
          end
          1: begin
            x = $urandom_range(1) ? l : l + rw;
            y = t + $urandom_range(rh);
          end
          2: begin
            x = l + $urandom_range(rw);
            y = $urandom_range(1) ? t : t + rh;
          end
          3: begin
            x = l - 64 + $urandom_range(rw + 128);
            y = t - 64 + $urandom_range(rh + 128);
          end
          default: begin
            x = l + rw / 2;
            y = t + rh / 2;
          end
        endcase
      end
      issue(npr_pkg::FUNC_QUERY, x, y, w, h, idx);
    end
  endtask

  initial begin : stimulus
    rst                = 1'b1;
    cmd_ch.valid       = 1'b0;
    cmd_ch.func        = npr_pkg::FUNC_ADD;
    cmd_ch.coord_x     = '0;
    cmd_ch.coord_y     = '0;
    cmd_ch.rect_width  = '0;
    cmd_ch.rect_height = '0;
    cmd_ch.entry_index = '0;
    tx_idle_pct   = 16;
    rx_idle_pct   = 61;
    hold_requests = 0;
    table_fill    = 0;
    recent_n      = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // empty table: query gives the point back, erase has a bad index
    issue(npr_pkg::FUNC_QUERY, -32768, 32767, 0, 0, 0);
    issue(npr_pkg::FUNC_ERASE, 0, 0, 0, 0, 0);
    // edges, corners and the four nearest-edge directions
    issue(npr_pkg::FUNC_ADD, 100, 200, 50, 30, 0);
    issue(npr_pkg::FUNC_QUERY, 100, 200, 0, 0, 0);
    issue(npr_pkg::FUNC_QUERY, 145, 215, 0, 0, 0);
    issue(npr_pkg::FUNC_QUERY, 150, 210, 0, 0, 0);
    issue(npr_pkg::FUNC_QUERY, 125, 215, 0, 0, 0);
    issue(npr_pkg::FUNC_ADD, 0, 0, 40, 40, 0);
    issue(npr_pkg::FUNC_QUERY, 20, 20, 0, 0, 0);
    issue(npr_pkg::FUNC_QUERY, 105, 215, 0, 0, 0);
    issue(npr_pkg::FUNC_QUERY, 125, 228, 0, 0, 0);
    issue(npr_pkg::FUNC_QUERY, 125, 203, 0, 0, 0);
    // zero size rectangle still offers a candidate
    issue(npr_pkg::FUNC_ADD, -500, -500, 0, 0, 0);
    issue(npr_pkg::FUNC_QUERY, -500, -500, 0, 0, 0);
    // edges past the coordinate range, nearest point saturates
    issue(npr_pkg::FUNC_ADD, 32767, 32767, 32767, 32767, 0);
    issue(npr_pkg::FUNC_QUERY, 32767, 32767, 0, 0, 0);
    issue(npr_pkg::FUNC_ADD, 32000, 0, 1000, 32767, 0);
    issue(npr_pkg::FUNC_QUERY, 32700, 16000, 0, 0, 0);
    issue(npr_pkg::FUNC_QUERY, -32768, -32768, 0, 0, 0);
    issue(npr_pkg::FUNC_ADD, -32768, -32768, 32767, 32767, 0);
    issue(npr_pkg::FUNC_QUERY, -32768, -32768, 0, 0, 0);
    // erase from the middle, erase past the end, clear
    issue(npr_pkg::FUNC_ERASE, 0, 0, 0, 0, 1);
    issue(npr_pkg::FUNC_ERASE, 0, 0, 0, 0, 15);
    issue(npr_pkg::FUNC_CLEAR, 0, 0, 0, 0, 0);
    issue(npr_pkg::FUNC_QUERY, 0, 0, 0, 0, 0);
    wait_drained();

    // random traffic under three idling mixes
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 16;
          rx_idle_pct = 61;
        end
        1: begin
          tx_idle_pct = 61;
          rx_idle_pct = 16;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        random_command();
        if (phase == 0 && n == 60) hold_requests++;
        if (phase == 1 && n == 80) wait_drained();
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
